>>> design/rfc_pkg.sv
`timescale 1ns / 1ps

package rfc_pkg;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [8:0]  READ_LENGTH = 9'd8;
  localparam logic [8:0]  WRITE_EXTRA = 9'd9;
  localparam logic [8:0]  COUNT_MAX   = 9'd511;
  localparam logic [8:0]  LEN_BYTE_IDX = 9'd6;

  localparam logic [7:0] FC_READ_SINGLE = 8'h42;
  localparam logic [7:0] FC_READ_LO     = 8'h45;
  localparam logic [7:0] FC_READ_HI     = 8'h49;
  localparam logic [7:0] FC_WRITE_LO    = 8'h50;
  localparam logic [7:0] FC_WRITE_HI    = 8'h54;

  typedef enum logic [1:0] {
    VERDICT_OK       = 2'd0,
    VERDICT_BAD_ADDR = 2'd1,
    VERDICT_BAD_FUNC = 2'd2,
    VERDICT_BAD_CRC  = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } rfc_item_t;

  typedef struct packed {
    verdict_t   verdict;
    logic [7:0] function_code;
    logic       is_write;
    logic [8:0] frame_length;
  } rfc_result_t;

  function automatic logic is_read_code(input logic [7:0] c);
    return (c == FC_READ_SINGLE) || ((c >= FC_READ_LO) && (c <= FC_READ_HI));
  endfunction

  function automatic logic is_write_code(input logic [7:0] c);
    return (c >= FC_WRITE_LO) && (c <= FC_WRITE_HI);
  endfunction

  // Bit-wise reflected CRC-16 over one byte, unrolled by synthesis.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> design/rfc_in_stage.sv
`timescale 1ns / 1ps

module rfc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rfc_pkg::rfc_item_t in_item,
  input  logic              s1_take,
  output logic              s1_valid,
  output rfc_pkg::rfc_item_t s1_item
);

  logic               valid_r, valid_nxt;
  rfc_pkg::rfc_item_t item_r;

  assign in_ready = !valid_r || s1_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

>>> design/rfc_check_core.sv
`timescale 1ns / 1ps

module rfc_check_core #(
  parameter int MIN_FRAME = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s1_valid,
  input  rfc_pkg::rfc_item_t   s1_item,
  output logic                 s1_take,
  input  logic [7:0]           station_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rfc_pkg::rfc_result_t out_result
);

  logic [8:0]  byte_count_r, byte_count_nxt;
  logic [15:0] running_crc_r, running_crc_nxt;
  logic [7:0]  address_seen_r, address_seen_nxt;
  logic [7:0]  command_seen_r, command_seen_nxt;
  logic [8:0]  expected_length_r, expected_length_nxt;
  logic        crc_low_match_r, crc_low_match_nxt;
  logic        verdict_given_r, verdict_given_nxt;
  logic        out_valid_r, out_valid_nxt;
  rfc_pkg::rfc_result_t result_r, result_nxt;

  logic       fire;
  logic [7:0] b;
  logic [8:0] cnt0;
  logic [9:0] idx_p2, idx_p1, exp_w;
  logic       wr, rd;

  assign s1_take = s1_valid && (!out_valid_r || out_ready);
  assign b       = s1_item.rx_byte;

  always_comb begin
    // a frame start clears the frame state before the byte is applied
    if (s1_item.frame_start) begin
      cnt0                = '0;
      running_crc_nxt     = rfc_pkg::CRC_INIT;
      address_seen_nxt    = '0;
      command_seen_nxt    = '0;
      expected_length_nxt = '0;
      crc_low_match_nxt   = 1'b0;
      verdict_given_nxt   = 1'b0;
    end else begin
      cnt0                = byte_count_r;
      running_crc_nxt     = running_crc_r;
      address_seen_nxt    = address_seen_r;
      command_seen_nxt    = command_seen_r;
      expected_length_nxt = expected_length_r;
      crc_low_match_nxt   = crc_low_match_r;
      verdict_given_nxt   = verdict_given_r;
    end
    byte_count_nxt = cnt0;
    fire           = 1'b0;
    result_nxt     = '0;
    idx_p2         = {1'b0, cnt0} + 10'd2;
    idx_p1         = {1'b0, cnt0} + 10'd1;
    exp_w          = '0;
    wr             = 1'b0;
    rd             = 1'b0;

    if (!verdict_given_nxt) begin
      if (cnt0 == 9'd0) begin
        address_seen_nxt = b;
      end else if (cnt0 == 9'd1) begin
        command_seen_nxt = b;
        if (rfc_pkg::is_read_code(b)) begin
          expected_length_nxt = rfc_pkg::READ_LENGTH;
        end
      end else if (cnt0 == rfc_pkg::LEN_BYTE_IDX && rfc_pkg::is_write_code(command_seen_nxt)) begin
        expected_length_nxt = {1'b0, b} + rfc_pkg::WRITE_EXTRA;
      end

      exp_w = {1'b0, expected_length_nxt};
      if (expected_length_nxt == 9'd0 || idx_p2 < exp_w) begin
        running_crc_nxt = rfc_pkg::crc_byte(running_crc_nxt, b);
      end else if (idx_p2 == exp_w) begin
        crc_low_match_nxt = (b == running_crc_nxt[7:0]);
      end else if (idx_p1 == exp_w) begin
        crc_low_match_nxt = crc_low_match_nxt && (b == running_crc_nxt[15:8]);
      end

      if (cnt0 != rfc_pkg::COUNT_MAX) begin
        byte_count_nxt = cnt0 + 9'd1;
      end

      wr = rfc_pkg::is_write_code(command_seen_nxt);
      rd = rfc_pkg::is_read_code(command_seen_nxt);
      result_nxt.function_code = command_seen_nxt;
      if (byte_count_nxt >= 9'(MIN_FRAME) && byte_count_nxt >= 9'd2) begin
        if (address_seen_nxt != station_address) begin
          fire               = 1'b1;
          result_nxt.verdict = rfc_pkg::VERDICT_BAD_ADDR;
        end else if (!wr && !rd) begin
          fire               = 1'b1;
          result_nxt.verdict = rfc_pkg::VERDICT_BAD_FUNC;
        end else if (expected_length_nxt != 9'd0 && byte_count_nxt >= expected_length_nxt) begin
          fire                    = 1'b1;
          result_nxt.verdict      = crc_low_match_nxt ? rfc_pkg::VERDICT_OK
                                                      : rfc_pkg::VERDICT_BAD_CRC;
          result_nxt.is_write     = wr;
          result_nxt.frame_length = expected_length_nxt;
        end
      end
      if (fire) begin
        verdict_given_nxt = 1'b1;
      end
    end

    out_valid_nxt = out_valid_r && !out_ready;
    if (s1_take && fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r      <= '0;
      running_crc_r     <= rfc_pkg::CRC_INIT;
      address_seen_r    <= '0;
      command_seen_r    <= '0;
      expected_length_r <= '0;
      crc_low_match_r   <= 1'b0;
      verdict_given_r   <= 1'b1;
      out_valid_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_take) begin
        byte_count_r      <= byte_count_nxt;
        running_crc_r     <= running_crc_nxt;
        address_seen_r    <= address_seen_nxt;
        command_seen_r    <= command_seen_nxt;
        expected_length_r <= expected_length_nxt;
        crc_low_match_r   <= crc_low_match_nxt;
        verdict_given_r   <= verdict_given_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

`ifndef SYNTHESIS
  // rejected frames carry no write flag and no length
  a_reject_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (result_r.verdict == rfc_pkg::VERDICT_BAD_ADDR ||
                    result_r.verdict == rfc_pkg::VERDICT_BAD_FUNC)
    |-> (!result_r.is_write && result_r.frame_length == 9'd0))
    else $error("rejected frame carries length or write flag");

  a_judged_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (result_r.verdict == rfc_pkg::VERDICT_OK ||
                    result_r.verdict == rfc_pkg::VERDICT_BAD_CRC)
    |-> (result_r.frame_length >= rfc_pkg::READ_LENGTH))
    else $error("checksum verdict without a valid frame length");

  a_write_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.is_write |-> result_r.frame_length >= rfc_pkg::WRITE_EXTRA)
    else $error("write frame shorter than its fixed part");

  a_one_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    s1_take && fire |=> verdict_given_r)
    else $error("verdict issued but frame not closed");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !s1_take)
    else $error("request consumed while result stalled");
`endif

endmodule

>>> design/rtu_request_frame_checker_unit.sv
`timescale 1ns / 1ps

// Modbus-RTU request frame checker. Takes one received byte per request
// (in_frame_start marks the first byte of a frame) and returns one verdict
// per frame: accepted, wrong station address, unknown function code or
// checksum mismatch, together with the function code, the write flag and
// the expected frame length. Throughput is one byte per clock; input
// stalls only while a verdict waits on out_ready. A byte goes through an
// input register and the checker stage, whose combinational CRC-16 byte
// update sets the clock path and which registers the verdict. The user
// must write the station address through the cfg port only while no
// frame is in flight; the block itself does not enforce this.
module rtu_request_frame_checker_unit #(
  parameter int MIN_FRAME = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_verdict,
  output logic [7:0] out_function_code,
  output logic       out_is_write,
  output logic [8:0] out_frame_length,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_station_address
);

  logic [7:0]           station_address_r;
  rfc_pkg::rfc_item_t   in_item, s1_item;
  rfc_pkg::rfc_result_t result;
  logic                 s1_valid, s1_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_address_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      station_address_r <= cfg_station_address;
    end
  end

  assign in_item.rx_byte     = in_rx_byte;
  assign in_item.frame_start = in_frame_start;

  rfc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  rfc_check_core #(
    .MIN_FRAME (MIN_FRAME)
  ) u_check_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .s1_valid        (s1_valid),
    .s1_item         (s1_item),
    .s1_take         (s1_take),
    .station_address (station_address_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result      (result)
  );

  assign out_verdict       = result.verdict;
  assign out_function_code = result.function_code;
  assign out_is_write      = result.is_write;
  assign out_frame_length  = result.frame_length;

endmodule

>>> tb/sv/tb_rtu_request_frame_checker_unit.sv
`timescale 1ns / 1ps

class frame_verdict_scoreboard;
  int                   min_bytes;
  logic [7:0]           station_addr;
  logic [8:0]           byte_cnt;
  logic [15:0]          crc;
  logic [7:0]           addr_byte;
  logic [7:0]           func_byte;
  logic [8:0]           exp_len;
  bit                   crc_ok;
  bit                   judged;
  rfc_pkg::rfc_result_t verdicts_due[$];
  int unsigned          mismatches;

  function new(int min_frame);
    min_bytes    = min_frame;
    station_addr = 8'h00;
    byte_cnt     = '0;
    crc          = rfc_pkg::CRC_INIT;
    addr_byte    = '0;
    func_byte    = '0;
    exp_len      = '0;
    crc_ok       = 1'b0;
    judged       = 1'b1;  // idle until the first frame start
    mismatches   = 0;
  endfunction

  function bit read_group(logic [7:0] c);
    return (c == rfc_pkg::FC_READ_SINGLE) ||
           (c >= rfc_pkg::FC_READ_LO && c <= rfc_pkg::FC_READ_HI);
  endfunction

  function bit write_group(logic [7:0] c);
    return c >= rfc_pkg::FC_WRITE_LO && c <= rfc_pkg::FC_WRITE_HI;
  endfunction

  function logic [15:0] crc16_update(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ rfc_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function int pending();
    return verdicts_due.size();
  endfunction

  function void note_request(logic [7:0] b, logic s);
    int                   idx;
    int                   n;
    bit                   wr;
    rfc_pkg::rfc_result_t r;
    if (s) begin
      byte_cnt  = '0;
      crc       = rfc_pkg::CRC_INIT;
      addr_byte = '0;
      func_byte = '0;
      exp_len   = '0;
      crc_ok    = 1'b0;
      judged    = 1'b0;
    end
    if (judged) return;
    idx = byte_cnt;
    if (idx == 0) begin
      addr_byte = b;
    end else if (idx == 1) begin
      func_byte = b;
      if (read_group(b)) exp_len = rfc_pkg::READ_LENGTH;
    end else if (idx == 6 && write_group(func_byte)) begin
      exp_len = {1'b0, b} + rfc_pkg::WRITE_EXTRA;
    end
    // checksum bytes are compared, everything before them is folded in
    if (exp_len == 0 || idx + 2 < exp_len) crc = crc16_update(crc, b);
    else if (idx + 2 == exp_len) crc_ok = (b == crc[7:0]);
    else if (idx + 1 == exp_len) crc_ok = crc_ok && (b == crc[15:8]);
    if (byte_cnt < rfc_pkg::COUNT_MAX) byte_cnt++;
    n = byte_cnt;
    if (n < min_bytes || n < 2) return;
    wr = write_group(func_byte);
    r  = '0;
    if (addr_byte != station_addr) begin
      r.verdict = rfc_pkg::VERDICT_BAD_ADDR;
    end else if (!wr && !read_group(func_byte)) begin
      r.verdict = rfc_pkg::VERDICT_BAD_FUNC;
    end else if (exp_len != 0 && n >= exp_len) begin
      r.verdict      = crc_ok ? rfc_pkg::VERDICT_OK : rfc_pkg::VERDICT_BAD_CRC;
      r.is_write     = wr;
      r.frame_length = exp_len;
    end else begin
      return;
    end
    judged          = 1'b1;
    r.function_code = func_byte;
    verdicts_due.push_back(r);
  endfunction

  function void check_result(logic [1:0] v, logic [7:0] fc, logic w, logic [8:0] len);
    rfc_pkg::rfc_result_t e;
    if (verdicts_due.size() == 0) begin
      $error("verdict %0d for function 0x%02h with no frame pending", v, fc);
      mismatches++;
      return;
    end
    e = verdicts_due.pop_front();
    if (v !== e.verdict) begin
      $error("verdict: expected %0d, got %0d", e.verdict, v);
      mismatches++;
    end
    if (fc !== e.function_code) begin
      $error("function_code: expected 0x%02h, got 0x%02h", e.function_code, fc);
      mismatches++;
    end
    if (w !== e.is_write) begin
      $error("is_write: expected %0d, got %0d", e.is_write, w);
      mismatches++;
    end
    if (len !== e.frame_length) begin
      $error("frame_length: expected %0d, got %0d", e.frame_length, len);
      mismatches++;
    end
  endfunction
endclass

module tb_rtu_request_frame_checker_unit;

  localparam int MIN_FRAME  = 8;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_BYTES = 120;

  typedef enum int {
    FLAW_NONE,
    FLAW_CRC_LO,
    FLAW_CRC_HI,
    FLAW_CRC_BOTH,
    FLAW_TRUNCATE
  } frame_flaw_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       in_frame_start;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_verdict;
  logic [7:0] out_function_code;
  logic       out_is_write;
  logic [8:0] out_frame_length;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_station_address;

  frame_verdict_scoreboard sb;

  int         tx_idle_pct;
  int         rx_idle_pct;
  int         hold_cycles;
  int         bytes_sent;
  int         stall_cnt;
  logic [7:0] station;

  rtu_request_frame_checker_unit #(.MIN_FRAME(MIN_FRAME)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .in_frame_start      (in_frame_start),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_verdict         (out_verdict),
    .out_function_code   (out_function_code),
    .out_is_write        (out_is_write),
    .out_frame_length    (out_frame_length),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_station_address (cfg_station_address)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // monitors
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.station_addr = cfg_station_address;
      if (in_valid && in_ready) sb.note_request(in_rx_byte, in_frame_start);
      if (out_valid && out_ready)
        sb.check_result(out_verdict, out_function_code, out_is_write, out_frame_length);
    end
  end

  // receiver: random backpressure, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("rtu_request_frame_checker_unit regression: fail");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_rx_byte     <= b;
    in_frame_start <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_station(input logic [7:0] a);
    wait_drained();
    // a byte that gave no verdict may still be in the pipe
    repeat (6) @(posedge clk);
    @(negedge clk);
    cfg_valid           <= 1'b1;
    cfg_station_address <= a;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    station = a;
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] fc, input int len_field,
                            input frame_flaw_t flaw, input int trailing);
    logic [7:0]  frame_bytes[$];
    logic [15:0] c;
    int          total;
    int          count;
    if (sb.write_group(fc)) total = len_field + 9;
    else if (sb.read_group(fc)) total = 8;
    else total = $urandom_range(8, 12);
    frame_bytes.push_back(addr);
    frame_bytes.push_back(fc);
    for (int i = 2; i < total - 2; i++)
      frame_bytes.push_back((i == 6 && sb.write_group(fc)) ? len_field[7:0] : 8'($urandom));
    c = rfc_pkg::CRC_INIT;
    foreach (frame_bytes[i]) c = sb.crc16_update(c, frame_bytes[i]);
    if (flaw == FLAW_CRC_LO || flaw == FLAW_CRC_BOTH) c[7:0] ^= 8'($urandom_range(1, 255));
    if (flaw == FLAW_CRC_HI || flaw == FLAW_CRC_BOTH) c[15:8] ^= 8'($urandom_range(1, 255));
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
    count = (flaw == FLAW_TRUNCATE) ? $urandom_range(1, total - 1) : total;
    for (int i = 0; i < count; i++) send_byte(frame_bytes[i], i == 0);
    repeat (trailing) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_random_frame();
    int          pick;
    int          len_field;
    logic [7:0]  addr;
    logic [7:0]  fc;
    frame_flaw_t flaw;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // line noise, frame start set now and then
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(7) == 0);
      return;
    end
    addr = ($urandom_range(9) == 0) ? station ^ 8'($urandom_range(1, 255)) : station;
    if (pick < 50) begin
      fc = ($urandom_range(5) == 0) ? rfc_pkg::FC_READ_SINGLE
                                    : 8'(rfc_pkg::FC_READ_LO + $urandom_range(4));
    end else if (pick < 90) begin
      fc = 8'(rfc_pkg::FC_WRITE_LO + $urandom_range(4));
    end else begin
      fc = 8'($urandom);
      while (sb.read_group(fc) || sb.write_group(fc)) fc = 8'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 85) len_field = $urandom_range(0, 6);
    else if (pick < 97) len_field = $urandom_range(7, 40);
    else len_field = $urandom_range(200, 255);
    pick = $urandom_range(99);
    if (pick < 70) flaw = FLAW_NONE;
    else if (pick < 78) flaw = FLAW_CRC_LO;
    else if (pick < 86) flaw = FLAW_CRC_HI;
    else if (pick < 90) flaw = FLAW_CRC_BOTH;
    else flaw = FLAW_TRUNCATE;
    send_frame(addr, fc, len_field, flaw, ($urandom_range(4) == 0) ? $urandom_range(1, 4) : 0);
  endtask

  initial begin
    logic [7:0] odd_codes[7];
    int         nframes;
    sb                  = new(MIN_FRAME);
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_rx_byte          = 8'h00;
    in_frame_start      = 1'b0;
    out_ready           = 1'b0;
    cfg_valid           = 1'b0;
    cfg_station_address = 8'h00;
    tx_idle_pct         = 0;
    rx_idle_pct         = 0;
    hold_cycles         = 0;
    bytes_sent          = 0;
    stall_cnt           = 0;
    station             = 8'h00;
    odd_codes = '{8'h00, 8'hFF, rfc_pkg::FC_READ_SINGLE - 8'd1,
                  rfc_pkg::FC_READ_SINGLE + 8'd1, rfc_pkg::FC_READ_HI + 8'd1,
                  rfc_pkg::FC_WRITE_LO - 8'd1, rfc_pkg::FC_WRITE_HI + 8'd1};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    program_station(8'h00);
    // no frame start seen yet: ignored
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_frame(station, rfc_pkg::FC_READ_SINGLE, 0, FLAW_NONE, 0);
    for (int k = 0; k <= 4; k++)
      send_frame(station, 8'(rfc_pkg::FC_READ_LO + k), 0, FLAW_NONE, 0);
    for (int k = 0; k <= 4; k++)
      send_frame(station, 8'(rfc_pkg::FC_WRITE_LO + k), k, FLAW_NONE, 0);
    foreach (odd_codes[i]) send_frame(station, odd_codes[i], 0, FLAW_NONE, 0);
    send_frame(8'hFF, rfc_pkg::FC_READ_SINGLE, 0, FLAW_NONE, 0);
    send_frame(station, rfc_pkg::FC_READ_LO, 0, FLAW_CRC_LO, 0);
    send_frame(station, rfc_pkg::FC_WRITE_LO, 2, FLAW_CRC_HI, 0);
    send_frame(station, rfc_pkg::FC_WRITE_LO, 3, FLAW_TRUNCATE, 0);
    // bytes after the verdict are dropped
    send_frame(station, rfc_pkg::FC_READ_HI, 0, FLAW_NONE, 3);
    send_frame(station, rfc_pkg::FC_WRITE_HI, 255, FLAW_NONE, 0);
    send_frame(station, rfc_pkg::FC_READ_SINGLE, 0, FLAW_NONE, 0);
    program_station(8'hFF);
    send_frame(8'hFF, 8'(rfc_pkg::FC_READ_LO + 2), 0, FLAW_NONE, 0);
    send_frame(8'h00, rfc_pkg::FC_READ_SINGLE, 0, FLAW_NONE, 0);
    send_frame(station, rfc_pkg::FC_READ_SINGLE, 0, FLAW_NONE, 0);

    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      tx_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 86 : 0;
      rx_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 11 : 0;
      if (ph == 0) program_station(8'($urandom_range(1, 254)));
      else if (ph == 1) program_station(8'($urandom));
      else program_station(8'h00);
      bytes_sent = 0;
      nframes    = 0;
      while (bytes_sent < PHASE_BYTES) begin
        if (ph == 0 && nframes == 0) hold_cycles = 400;
        if (ph == 2 && nframes == 1) hold_cycles = 250;
        if (ph == 1 && nframes == 2) wait_drained();
        send_random_frame();
        nframes++;
      end
      // close on a judged frame so the next register write sees an idle block
      send_frame(station, rfc_pkg::FC_READ_SINGLE, 0, FLAW_NONE, 0);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("rtu_request_frame_checker_unit regression: pass");
    else
      $display("rtu_request_frame_checker_unit regression: fail");
    $finish;
  end

endmodule
